>>> design/rsa_pkg.sv
// ----------------------------------------------------------------------------
// Rational sum accumulator package
// Shared constants, types and controller states.
// ----------------------------------------------------------------------------
package rsa_pkg;

	localparam int unsigned DataWidth = 32;
	localparam int unsigned DenWidth = 31;
	localparam int unsigned StatusWidth = 2;
	localparam int unsigned DefaultWidth = 32;

	localparam logic [StatusWidth-1:0] StatusOk = 2'd0;
	localparam logic [StatusWidth-1:0] StatusZeroDen = 2'd1;
	localparam logic [StatusWidth-1:0] StatusOverflow = 2'd2;

	typedef enum logic [3:0] {
		StIdle,
		StGcdA,
		StDivA,
		StMul,
		StSum,
		StGcdB,
		StDivB,
		StCommit,
		StOut
	} state_t;

	typedef struct packed {
		logic load;
		logic gcd_start;
		logic div_start;
		logic mul;
		logic sum;
		logic commit;
	} cmd_t;

	typedef struct packed {
		logic zero_den;
		logic gcd_done;
		logic div_done;
	} sts_t;

endpackage

>>> design/rsa_stream_if.sv
// ----------------------------------------------------------------------------
// Stream interface
// Valid and ready handshake that carries a payload of a given type.
// ----------------------------------------------------------------------------
interface rsa_stream_if #(
	parameter type payload_t = logic
);
	logic valid;
	logic ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

>>> design/rsa_ctrl.sv
// ----------------------------------------------------------------------------
// Rational sum accumulator controller
// Sequences the gcd, divide, multiply, sum and commit steps of one transaction.
// ----------------------------------------------------------------------------
module rsa_ctrl (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	output logic out_valid,
	input  logic out_ready,
	output rsa_pkg::cmd_t cmd,
	input  rsa_pkg::sts_t sts
);
	import rsa_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= StIdle;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd = '0;
		in_ready = 1'b0;
		out_valid = 1'b0;
		case (state_q)
			StIdle: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d = StGcdA;
				end
			end
			StGcdA: begin
				if (sts.zero_den) begin
					state_d = StOut;
				end else begin
					cmd.gcd_start = 1'b1;
					state_d = StDivA;
				end
			end
			StDivA: begin
				if (sts.gcd_done) begin
					cmd.div_start = 1'b1;
					state_d = StMul;
				end
			end
			StMul: begin
				if (sts.div_done) begin
					cmd.mul = 1'b1;
					state_d = StSum;
				end
			end
			StSum: begin
				cmd.sum = 1'b1;
				state_d = StGcdB;
			end
			StGcdB: begin
				cmd.gcd_start = 1'b1;
				state_d = StDivB;
			end
			StDivB: begin
				if (sts.gcd_done) begin
					cmd.div_start = 1'b1;
					state_d = StCommit;
				end
			end
			StCommit: begin
				if (sts.div_done) begin
					cmd.commit = 1'b1;
					state_d = StOut;
				end
			end
			StOut: begin
				out_valid = 1'b1;
				if (out_ready) begin
					state_d = StIdle;
				end
			end
			default: begin
				state_d = StIdle;
			end
		endcase
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |=> out_valid)
		else $error("commit not followed by a result");
	assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid))
		else $error("input taken while a result waits");
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> out_valid)
		else $error("result dropped");
endmodule

>>> design/rsa_datapath.sv
// ----------------------------------------------------------------------------
// Rational sum accumulator datapath
// Accumulator, shared binary gcd unit, shared restoring divider and three multipliers.
// ----------------------------------------------------------------------------
module rsa_datapath #(
	parameter int unsigned WIDTH = rsa_pkg::DefaultWidth
) (
	input  logic clk,
	input  logic arst_n,
	input  logic [rsa_pkg::DataWidth-1:0] addend_num,
	input  logic [rsa_pkg::DataWidth-1:0] addend_den,
	input  logic restart,
	input  rsa_pkg::cmd_t cmd,
	output rsa_pkg::sts_t sts,
	output logic [rsa_pkg::DataWidth-1:0] sum_num,
	output logic [rsa_pkg::DenWidth-1:0] sum_den,
	output logic [rsa_pkg::StatusWidth-1:0] status
);
	import rsa_pkg::*;

	localparam int unsigned W = 64;
	localparam int unsigned CW = 7;
	localparam int unsigned MW = 33;
	localparam logic [W-1:0] Lim = (W'(1) << (WIDTH - 1)) - W'(1);

	logic signed [W-1:0] acc_num_q, acc_den_q;
	logic [W-1:0] xm_q, ym_q;
	logic neg_q, zero_den_q, restart_q;
	logic [StatusWidth-1:0] status_q;
	logic signed [W-1:0] p_q;
	logic signed [W-1:0] t1_q, d_q;
	logic [W-1:0] sm_mag;
	logic sneg_q;
	logic mul_phase_q;

	// Binary gcd state.
	logic [W-1:0] ga_q, gb_q;
	logic [CW-1:0] gk_q;
	logic gbusy_q, gdone_q;
	logic [W-1:0] g_q;

	// Divider state: divides two operands by g_q, one quotient bit of each per cycle.
	logic [W-1:0] q0_q, q1_q, r0_q, r1_q, n0_q, n1_q;
	logic [CW-1:0] dc_q;
	logic dbusy_q, ddone_q;

	logic [W-1:0] r0_sh, r1_sh;
	logic signed [W-1:0] acc_num_eff, acc_den_eff;
	logic signed [W-1:0] x_ext, y_ext;

	// All multiplier operands fit 33 signed bits.
	logic signed [MW-1:0] an_m, ad_m, q_m, p_m;
	logic signed [2*MW-1:0] prod_nq, prod_dq, prod_dp;

	assign x_ext = W'(signed'(addend_num));
	assign y_ext = W'(signed'(addend_den));
	assign acc_num_eff = restart_q ? '0 : acc_num_q;
	assign acc_den_eff = restart_q ? W'(1) : acc_den_q;

	assign an_m = acc_num_eff[MW-1:0];
	assign ad_m = acc_den_eff[MW-1:0];
	assign q_m = {1'b0, q1_q[MW-2:0]};
	assign p_m = p_q[MW-1:0];
	assign prod_nq = an_m * q_m;
	assign prod_dq = ad_m * q_m;
	assign prod_dp = ad_m * p_m;

	assign r0_sh = {r0_q[W-2:0], n0_q[W-1]};
	assign r1_sh = {r1_q[W-2:0], n1_q[W-1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_num_q <= '0;
			acc_den_q <= W'(1);
			gbusy_q <= 1'b0;
			gdone_q <= 1'b0;
			dbusy_q <= 1'b0;
			ddone_q <= 1'b0;
			mul_phase_q <= 1'b0;
			status_q <= StatusOk;
		end else begin
			gdone_q <= 1'b0;
			ddone_q <= 1'b0;
			if (cmd.load) begin
				restart_q <= restart;
				zero_den_q <= (addend_den == '0);
				neg_q <= addend_num[DataWidth-1] ^ addend_den[DataWidth-1];
				xm_q <= x_ext[W-1] ? -x_ext : x_ext;
				ym_q <= y_ext[W-1] ? -y_ext : y_ext;
				status_q <= (addend_den == '0) ? StatusZeroDen : StatusOk;
				if (restart) begin
					acc_num_q <= '0;
					acc_den_q <= W'(1);
				end
			end
			if (cmd.gcd_start) begin
				gbusy_q <= 1'b1;
				gk_q <= '0;
				ga_q <= mul_phase_q ? sm_mag : xm_q;
				gb_q <= mul_phase_q ? d_q : ym_q;
			end else if (gbusy_q) begin
				if (ga_q == '0 || gb_q == '0) begin
					g_q <= (ga_q | gb_q) << gk_q;
					gbusy_q <= 1'b0;
					gdone_q <= 1'b1;
				end else if (!ga_q[0] && !gb_q[0]) begin
					ga_q <= ga_q >> 1;
					gb_q <= gb_q >> 1;
					gk_q <= gk_q + CW'(1);
				end else if (!ga_q[0]) begin
					ga_q <= ga_q >> 1;
				end else if (!gb_q[0]) begin
					gb_q <= gb_q >> 1;
				end else if (ga_q >= gb_q) begin
					ga_q <= (ga_q - gb_q) >> 1;
				end else begin
					gb_q <= (gb_q - ga_q) >> 1;
				end
			end
			if (cmd.div_start) begin
				dbusy_q <= 1'b1;
				dc_q <= '0;
				r0_q <= '0;
				r1_q <= '0;
				n0_q <= mul_phase_q ? sm_mag : xm_q;
				n1_q <= mul_phase_q ? d_q : ym_q;
			end else if (dbusy_q) begin
				n0_q <= n0_q << 1;
				n1_q <= n1_q << 1;
				if (r0_sh >= g_q) begin
					r0_q <= r0_sh - g_q;
					q0_q <= {q0_q[W-2:0], 1'b1};
				end else begin
					r0_q <= r0_sh;
					q0_q <= {q0_q[W-2:0], 1'b0};
				end
				if (r1_sh >= g_q) begin
					r1_q <= r1_sh - g_q;
					q1_q <= {q1_q[W-2:0], 1'b1};
				end else begin
					r1_q <= r1_sh;
					q1_q <= {q1_q[W-2:0], 1'b0};
				end
				dc_q <= dc_q + CW'(1);
				if (dc_q == CW'(W - 1)) begin
					dbusy_q <= 1'b0;
					ddone_q <= 1'b1;
				end
			end
			if (cmd.mul) begin
				p_q <= (neg_q && q0_q != '0) ? -signed'(q0_q) : signed'(q0_q);
				t1_q <= prod_nq[W-1:0];
				d_q <= prod_dq[W-1:0];
				mul_phase_q <= 1'b1;
			end
			if (cmd.sum) begin
				t1_q <= t1_q + signed'(prod_dp[W-1:0]);
			end
			if (cmd.gcd_start && mul_phase_q) begin
				sneg_q <= t1_q[W-1];
			end
			if (cmd.commit) begin
				mul_phase_q <= 1'b0;
				if ((q0_q != '0 && q1_q > Lim) ||
					(sneg_q ? q0_q > Lim + W'(1) : q0_q > Lim)) begin
					status_q <= StatusOverflow;
				end else begin
					acc_num_q <= sneg_q ? -signed'(q0_q) : signed'(q0_q);
					acc_den_q <= (q0_q == '0) ? W'(1) : signed'(q1_q);
				end
			end
		end
	end

	assign sm_mag = t1_q[W-1] ? W'(-t1_q) : W'(t1_q);

	assign sts.zero_den = zero_den_q;
	assign sts.gcd_done = gdone_q;
	assign sts.div_done = ddone_q;

	assign sum_num = acc_num_q[DataWidth-1:0];
	assign sum_den = acc_den_q[DenWidth-1:0];
	assign status = status_q;

	assert property (@(posedge clk) disable iff (!arst_n)
		acc_den_q > 0)
		else $error("denominator not positive");
	assert property (@(posedge clk) disable iff (!arst_n)
		!(gbusy_q && dbusy_q))
		else $error("gcd and divider active together");
	assert property (@(posedge clk) disable iff (!arst_n)
		gdone_q |-> g_q != '0 || zero_den_q)
		else $error("zero gcd");
endmodule

>>> design/rational_sum_accumulator.sv
// ----------------------------------------------------------------------------
// Rational sum accumulator
// Keeps a running sum of signed fractions in lowest terms.
// A transaction takes two binary gcd runs and two bit-serial divisions.
// A zero denominator skips the gcd and divide steps and is answered from the output state.
// Throughput: one transaction at a time; the next is taken after the result leaves.
// Reset clears the sum to 0/1 and returns the controller to idle.
// ----------------------------------------------------------------------------
module rational_sum_accumulator #(
	parameter int unsigned WIDTH = rsa_pkg::DefaultWidth
) (
	input  logic clk,
	input  logic arst_n,
	rsa_stream_if.sink in_ch,
	rsa_stream_if.source out_ch
);
	import rsa_pkg::*;

	cmd_t cmd;
	sts_t sts;

	rsa_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_ch.valid),
		.in_ready(in_ch.ready),
		.out_valid(out_ch.valid),
		.out_ready(out_ch.ready),
		.cmd(cmd),
		.sts(sts)
	);

	rsa_datapath #(.WIDTH(WIDTH)) u_datapath (
		.clk(clk),
		.arst_n(arst_n),
		.addend_num(in_ch.payload.addend_num),
		.addend_den(in_ch.payload.addend_den),
		.restart(in_ch.payload.restart),
		.cmd(cmd),
		.sts(sts),
		.sum_num(out_ch.payload.sum_num),
		.sum_den(out_ch.payload.sum_den),
		.status(out_ch.payload.status)
	);
endmodule
